### rtl/mfq_pkg.sv
// shared constants, types and helpers of the feedback queue scheduler
`default_nettype none
package mfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_LEVELS  = 4;
    localparam int LVL_W       = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W      = LVL_W + PTR_W;
    localparam int MEM_DEPTH   = 1 << ADDR_W;
    localparam int ID_W        = 8;
    localparam int PC_W        = 16;
    localparam int Q_W         = 8;
    localparam int CFG_IDX_W   = 8;

    localparam logic [LVL_W-1:0] LAST_LEVEL = LVL_W'(NUM_LEVELS - 1);

    typedef enum logic {
        OP_ADMIT    = 1'b0,
        OP_DISPATCH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_ADMITTED   = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_DISPATCHED = 2'd2,
        STAT_EMPTY      = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] bound;
    } t_slot;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_slot             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [Q_W-1:0]   steps;
        logic             done;
        logic [PC_W-1:0]  newpc;
        logic [LVL_W-1:0] next_level;
    } t_slice_res;

    typedef struct packed {
        t_status          status;
        logic [ID_W-1:0]  ran_id;
        logic [LVL_W-1:0] ran_level;
        logic [PC_W-1:0]  slice_start_pc;
        logic [Q_W-1:0]   steps_run;
        logic             completed;
        logic [LVL_W-1:0] next_level;
    } t_result;

    typedef logic [NUM_LEVELS-1:0][Q_W-1:0] t_quantum_set;

    localparam t_quantum_set QUANTUM_RESET = {8'd8, 8'd4, 8'd2, 8'd1};

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/mfq_if.sv
// handshake channel interfaces: items in, results out, register writes
`default_nettype none
interface mfq_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [mfq_pkg::ID_W-1:0]      process_id;
    logic [mfq_pkg::PC_W-1:0]      start_pc;
    logic [mfq_pkg::PC_W-1:0]      upper_bound;
    logic [mfq_pkg::LVL_W-1:0]     level;

    modport source (output valid, operation, process_id, start_pc, upper_bound, level,
                    input ready);
    modport sink   (input valid, operation, process_id, start_pc, upper_bound, level,
                    output ready);
endinterface

interface mfq_out_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [mfq_pkg::ID_W-1:0]      ran_id;
    logic [mfq_pkg::LVL_W-1:0]     ran_level;
    logic [mfq_pkg::PC_W-1:0]      slice_start_pc;
    logic [mfq_pkg::Q_W-1:0]       steps_run;
    logic                          completed;
    logic [mfq_pkg::LVL_W-1:0]     next_level;

    modport source (output valid, status, ran_id, ran_level, slice_start_pc, steps_run,
                    completed, next_level, input ready);
    modport sink   (input valid, status, ran_id, ran_level, slice_start_pc, steps_run,
                    completed, next_level, output ready);
endinterface

interface mfq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mfq_pkg::CFG_IDX_W-1:0]   index;
    logic [mfq_pkg::Q_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/multilevel_feedback_queue_scheduler.sv
// top level: quantum registers, control and slot memory
//
//  channel  dir  handshake          payload
//  i_in     in   valid / ready      operation, process_id, start_pc, upper_bound, level
//  o_out    out  valid / ready      status, ran_id, ran_level, slice_start_pc,
//                                   steps_run, completed, next_level
//  i_cfg    in   valid / ready      index, data (quantum of level index)
//
//  admit, and dispatch of an empty scheduler, are answered from the idle state; a dispatch
//  otherwise reads the queue head from the slot memory, then writes back the demoted entry
//  results sit in an output register; i_in stalls while it holds an untaken beat
//  reset is synchronous and clears pointers and counts at once; no memory clearing pass
//  i_cfg is always ready, a write to an index above 3 is dropped
`default_nettype none
module multilevel_feedback_queue_scheduler (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mfq_in_if.sink    i_in,
    mfq_out_if.source o_out,
    mfq_cfg_if.sink   i_cfg
);

    mfq_pkg::t_quantum_set r_quantum;
    mfq_pkg::t_mem_req     mem_req;
    mfq_pkg::t_slot        mem_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= mfq_pkg::QUANTUM_RESET;
        end else if (i_cfg.valid && i_cfg.ready
                     && i_cfg.index < mfq_pkg::CFG_IDX_W'(mfq_pkg::NUM_LEVELS)) begin
            r_quantum[i_cfg.index[mfq_pkg::LVL_W-1:0]] <= i_cfg.data;
        end
    end

    mfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_quantum   (r_quantum),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    mfq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule
`default_nettype wire

### rtl/mfq_ram.sv
// slot memory: one write port, one read port with registered read data
`default_nettype none
module mfq_ram (
    input  wire logic              i_clk,
    input  wire mfq_pkg::t_mem_req i_req,
    output mfq_pkg::t_slot         o_rdata
);

    mfq_pkg::t_slot r_mem [mfq_pkg::MEM_DEPTH];
    mfq_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/mfq_slice.sv
// time slice arithmetic: steps run, new pc, completion and demotion level
`default_nettype none
module mfq_slice (
    input  wire mfq_pkg::t_slot              i_slot,
    input  wire logic [mfq_pkg::Q_W-1:0]     i_quantum,
    input  wire logic [mfq_pkg::LVL_W-1:0]   i_level,
    output mfq_pkg::t_slice_res              o_res
);

    logic                       pc_gt;
    logic                       q_lt;
    logic [mfq_pkg::PC_W:0]     room;

    always_comb begin
        pc_gt = i_slot.pc > i_slot.bound;
        // steps left up to and including the bound
        room  = {1'b0, i_slot.bound} - {1'b0, i_slot.pc} + (mfq_pkg::PC_W + 1)'(1);
        q_lt  = (mfq_pkg::PC_W + 1)'(i_quantum) < room;

        if (pc_gt) begin
            o_res.steps = '0;
        end else if (q_lt) begin
            o_res.steps = i_quantum;
        end else begin
            o_res.steps = room[mfq_pkg::Q_W-1:0];
        end
        // a full run up to the bound always carries pc past it
        o_res.done       = pc_gt || !q_lt;
        o_res.newpc      = i_slot.pc + mfq_pkg::PC_W'(o_res.steps);
        o_res.next_level = (i_level == mfq_pkg::LAST_LEVEL) ? i_level
                                                           : i_level + mfq_pkg::LVL_W'(1);
    end

endmodule
`default_nettype wire

### rtl/mfq_ctrl.sv
// queue pointers, counts, sequencing of admit and dispatch, result register
`default_nettype none
module mfq_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    mfq_in_if.sink                      i_in,
    mfq_out_if.source                   o_out,
    input  wire mfq_pkg::t_quantum_set  i_quantum,
    output mfq_pkg::t_mem_req           o_mem_req,
    input  wire mfq_pkg::t_slot         i_mem_rdata
);

    mfq_pkg::t_state                 r_state, n_state;
    logic [mfq_pkg::PTR_W-1:0]       r_head   [mfq_pkg::NUM_LEVELS];
    logic [mfq_pkg::PTR_W-1:0]       n_head   [mfq_pkg::NUM_LEVELS];
    logic [mfq_pkg::PTR_W-1:0]       r_tail   [mfq_pkg::NUM_LEVELS];
    logic [mfq_pkg::PTR_W-1:0]       n_tail   [mfq_pkg::NUM_LEVELS];
    logic [mfq_pkg::CNT_W-1:0]       r_count  [mfq_pkg::NUM_LEVELS];
    logic [mfq_pkg::CNT_W-1:0]       n_count  [mfq_pkg::NUM_LEVELS];
    logic [mfq_pkg::CNT_W-1:0]       r_active, n_active;
    logic [mfq_pkg::LVL_W-1:0]       r_lv, n_lv;
    logic                            r_out_valid, n_out_valid;
    mfq_pkg::t_result                r_out, n_out;

    logic                            in_fire;
    logic                            is_dispatch;
    logic                            any_ne;
    logic [mfq_pkg::LVL_W-1:0]       sel_lv;
    logic                            is_full;
    logic                            out_free;
    mfq_pkg::t_slot                  slot_new;
    mfq_pkg::t_slice_res             slice;

    mfq_slice u_slice (
        .i_slot    (i_mem_rdata),
        .i_quantum (i_quantum[r_lv]),
        .i_level   (r_lv),
        .o_res     (slice)
    );

    // lowest-numbered level holding a process
    always_comb begin
        any_ne = 1'b0;
        sel_lv = '0;
        for (int l = mfq_pkg::NUM_LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                any_ne = 1'b1;
                sel_lv = mfq_pkg::LVL_W'(l);
            end
        end
    end

    assign is_dispatch   = i_in.operation == mfq_pkg::OP_DISPATCH;
    assign in_fire       = i_in.valid && i_in.ready;
    assign is_full       = r_active >= mfq_pkg::CNT_W'(mfq_pkg::QUEUE_DEPTH);
    assign out_free      = !r_out_valid || o_out.ready;
    assign slot_new.id    = i_in.process_id;
    assign slot_new.pc    = i_in.start_pc;
    assign slot_new.bound = i_in.upper_bound;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mfq_pkg::ST_IDLE: begin
                if (in_fire && is_dispatch && any_ne) begin
                    n_state = mfq_pkg::ST_READ;
                end
            end
            mfq_pkg::ST_READ: begin
                n_state = mfq_pkg::ST_IDLE;
            end
            default: begin
                n_state = mfq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs: handshake and memory port
    assign i_in.ready = (r_state == mfq_pkg::ST_IDLE) && out_free;

    always_comb begin
        o_mem_req = '0;
        case (r_state)
            mfq_pkg::ST_IDLE: begin
                o_mem_req.re    = in_fire && is_dispatch && any_ne;
                o_mem_req.raddr = {sel_lv, r_head[sel_lv]};
                o_mem_req.we    = in_fire && !is_dispatch && !is_full;
                o_mem_req.waddr = {i_in.level, r_tail[i_in.level]};
                o_mem_req.wdata = slot_new;
            end
            mfq_pkg::ST_READ: begin
                // demoted process goes back at the tail of its new level
                o_mem_req.we          = !slice.done;
                o_mem_req.waddr       = {slice.next_level, r_tail[slice.next_level]};
                o_mem_req.wdata.id    = i_mem_rdata.id;
                o_mem_req.wdata.pc    = slice.newpc;
                o_mem_req.wdata.bound = i_mem_rdata.bound;
            end
            default: begin
                o_mem_req = '0;
            end
        endcase
    end

    // pointer, count and result updates
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_active    = r_active;
        n_lv        = r_lv;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mfq_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_out = '0;
                    if (!is_dispatch) begin
                        n_out_valid = 1'b1;
                        if (is_full) begin
                            n_out.status = mfq_pkg::STAT_FULL;
                        end else begin
                            n_out.status          = mfq_pkg::STAT_ADMITTED;
                            n_tail[i_in.level]  = mfq_pkg::next_ptr(r_tail[i_in.level]);
                            n_count[i_in.level] = r_count[i_in.level]
                                                  + mfq_pkg::CNT_W'(1);
                            n_active              = r_active + mfq_pkg::CNT_W'(1);
                        end
                    end else if (!any_ne) begin
                        n_out_valid  = 1'b1;
                        n_out.status = mfq_pkg::STAT_EMPTY;
                    end else begin
                        n_lv            = sel_lv;
                        n_head[sel_lv]  = mfq_pkg::next_ptr(r_head[sel_lv]);
                        n_count[sel_lv] = r_count[sel_lv] - mfq_pkg::CNT_W'(1);
                    end
                end
            end
            mfq_pkg::ST_READ: begin
                n_out_valid          = 1'b1;
                n_out.status         = mfq_pkg::STAT_DISPATCHED;
                n_out.ran_id         = i_mem_rdata.id;
                n_out.ran_level      = r_lv;
                n_out.slice_start_pc = i_mem_rdata.pc;
                n_out.steps_run      = slice.steps;
                n_out.completed      = slice.done;
                if (slice.done) begin
                    n_out.next_level = '0;
                    n_active         = r_active - mfq_pkg::CNT_W'(1);
                end else begin
                    n_out.next_level          = slice.next_level;
                    n_tail[slice.next_level]  = mfq_pkg::next_ptr(r_tail[slice.next_level]);
                    n_count[slice.next_level] = r_count[slice.next_level]
                                                + mfq_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfq_pkg::ST_IDLE;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < mfq_pkg::NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv  <= n_lv;
        r_out <= n_out;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.ran_id         = r_out.ran_id;
    assign o_out.ran_level      = r_out.ran_level;
    assign o_out.slice_start_pc = r_out.slice_start_pc;
    assign o_out.steps_run      = r_out.steps_run;
    assign o_out.completed      = r_out.completed;
    assign o_out.next_level     = r_out.next_level;

    // the occupancy total tracks the per-level counts plus the head being read
    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == r_count[0] + r_count[1] + r_count[2] + r_count[3]
                    + mfq_pkg::CNT_W'(r_state == mfq_pkg::ST_READ))
        else $error("active total differs from sum of level counts");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= mfq_pkg::CNT_W'(mfq_pkg::QUEUE_DEPTH))
        else $error("active total above queue depth");

    // the result slot is always free when the head read comes back
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mfq_pkg::ST_READ |-> !r_out_valid)
        else $error("result register busy during dispatch read");

    a_dispatch_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_dispatch && any_ne) |=> (r_state == mfq_pkg::ST_READ && !i_in.ready))
        else $error("dispatch did not enter read phase");

endmodule
`default_nettype wire

### tb/sv/multilevel_feedback_queue_scheduler_test.sv
// self-checking testbench for the four-level feedback queue scheduler
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler_test;
    import mfq_pkg::*;

    localparam int RUN_LIMIT = 200000;
    localparam int LONG_HOLD = 250;

    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [PC_W-1:0]  pc;
        logic [PC_W-1:0]  bound;
        logic [LVL_W-1:0] lvl;
    } t_job_beat;

    typedef struct {
        t_job_beat beat;
        int        gap_after;
        bit        calm;
    } t_backlog_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mfq_in_if  job_if ();
    mfq_out_if res_if ();
    mfq_cfg_if cfg_if ();

    multilevel_feedback_queue_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (job_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    // driven values, all known from time zero
    logic                 job_valid = 1'b0;
    t_job_beat            on_wire = '0;
    logic                 rx_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [Q_W-1:0]       cfg_data = '0;

    assign job_if.valid       = job_valid;
    assign job_if.operation   = on_wire.op;
    assign job_if.process_id  = on_wire.id;
    assign job_if.start_pc    = on_wire.pc;
    assign job_if.upper_bound = on_wire.bound;
    assign job_if.level       = on_wire.lvl;
    assign res_if.ready       = rx_ready;
    assign cfg_if.valid       = cfg_valid;
    assign cfg_if.index       = cfg_index;
    assign cfg_if.data        = cfg_data;

    always begin
        #4;
        i_clk = ~i_clk;
    end

    // scheduler shadow state
    t_slot          lvl_slots [NUM_LEVELS][QUEUE_DEPTH];
    int             lvl_head [NUM_LEVELS];
    int             lvl_fill [NUM_LEVELS];
    int             live_total = 0;
    logic [Q_W-1:0] slice_quantum [NUM_LEVELS];

    t_backlog_entry job_backlog [$];
    t_result        predicted_results [$];

    int pushed_count = 0;
    int accepted_count = 0;
    int result_count = 0;
    int errors = 0;
    int status_seen [4];
    int finished_count = 0;
    int demoted_count = 0;

    bit in_taken = 1'b0;
    bit quiet_tail = 1'b0;
    int gap_left = 0;
    int unsigned cycle_count = 0;

    function automatic void append_slot(input int lv, input t_slot s);
        lvl_slots[lv][(lvl_head[lv] + lvl_fill[lv]) % QUEUE_DEPTH] = s;
        lvl_fill[lv]++;
    endfunction

    function automatic t_result schedule_job(input t_job_beat b);
        t_result          r;
        t_slot            s;
        int               lv;
        int unsigned      room;
        int unsigned      steps;
        int unsigned      reach;
        logic [LVL_W-1:0] down;
        r = '0;
        if (b.op == OP_ADMIT) begin
            if (live_total >= QUEUE_DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                s.id = b.id;
                s.pc = b.pc;
                s.bound = b.bound;
                append_slot(int'(b.lvl), s);
                live_total++;
                r.status = STAT_ADMITTED;
            end
        end else begin
            lv = 0;
            while (lv < NUM_LEVELS && lvl_fill[lv] == 0) lv++;
            if (lv == NUM_LEVELS) begin
                r.status = STAT_EMPTY;
            end else begin
                s = lvl_slots[lv][lvl_head[lv]];
                lvl_head[lv] = (lvl_head[lv] + 1) % QUEUE_DEPTH;
                lvl_fill[lv]--;
                steps = 0;
                if (s.pc <= s.bound) begin
                    room = 32'(s.bound) - 32'(s.pc) + 1;
                    steps = (32'(slice_quantum[lv]) < room) ? 32'(slice_quantum[lv]) : room;
                end
                // may reach 65536 when the bound is the top address
                reach = 32'(s.pc) + steps;
                r.status = STAT_DISPATCHED;
                r.ran_id = s.id;
                r.ran_level = LVL_W'(lv);
                r.slice_start_pc = s.pc;
                r.steps_run = steps[Q_W-1:0];
                r.completed = (reach > 32'(s.bound));
                if (r.completed) begin
                    live_total--;
                end else begin
                    down = (lv < NUM_LEVELS - 1) ? LVL_W'(lv + 1) : LAST_LEVEL;
                    s.pc = reach[PC_W-1:0];
                    append_slot(int'(down), s);
                    r.next_level = down;
                end
            end
        end
        return r;
    endfunction

    function automatic t_job_beat mk_beat(input t_op op, input int id, input int pc,
                                          input int bound, input int lvl);
        t_job_beat b;
        b.op = op;
        b.id = ID_W'(id);
        b.pc = PC_W'(pc);
        b.bound = PC_W'(bound);
        b.lvl = LVL_W'(lvl);
        return b;
    endfunction

    function automatic t_job_beat random_beat(input int admit_pct);
        t_job_beat   b;
        int unsigned pc;
        int unsigned bound;
        int unsigned pick;
        b.op = ($urandom_range(1, 100) <= admit_pct) ? OP_ADMIT : OP_DISPATCH;
        b.id = ID_W'($urandom);
        b.lvl = LVL_W'($urandom);
        pick = $urandom_range(0, 39);
        if (pick < 24) begin
            pc = $urandom_range(0, 65535);
            bound = pc + $urandom_range(0, 60);
            if (bound > 65535) bound = 65535;
        end else if (pick < 30) begin
            // already past its bound
            pc = $urandom_range(1, 65535);
            bound = $urandom_range(0, pc - 1);
        end else if (pick == 30) begin
            pc = $urandom;
            bound = $urandom;
        end else if (pick < 35) begin
            pc = $urandom_range(65500, 65535);
            bound = 65535;
        end else begin
            pc = $urandom_range(0, 40);
            bound = pc + $urandom_range(0, 600);
        end
        b.pc = pc[PC_W-1:0];
        b.bound = bound[PC_W-1:0];
        return b;
    endfunction

    function automatic void enqueue(input t_job_beat b, input int gap, input bit calm);
        t_backlog_entry e;
        e.beat = b;
        e.gap_after = gap;
        e.calm = calm;
        job_backlog.push_back(e);
        pushed_count++;
    endfunction

    task automatic add_random_jobs(input int count, input int admit_pct, input bit calm);
        int stretch_left;
        bit choppy;
        int gap;
        stretch_left = 0;
        choppy = 1'b0;
        repeat (count) begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(10, 40);
                choppy = ($urandom_range(0, 2) != 0);
            end
            stretch_left--;
            gap = (!calm && choppy && $urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
            enqueue(random_beat(admit_pct), gap, calm);
        end
    endtask

    task automatic write_quantum(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx < NUM_LEVELS) slice_quantum[idx[LVL_W-1:0]] = val;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_quanta(input int q0, input int q1, input int q2, input int q3);
        write_quantum(8'd0, Q_W'(q0));
        write_quantum(8'd1, Q_W'(q1));
        write_quantum(8'd2, Q_W'(q2));
        write_quantum(8'd3, Q_W'(q3));
    endtask

    task automatic drain();
        wait (accepted_count == pushed_count && result_count == pushed_count);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: offers the next job once the current beat is taken
    always @(negedge i_clk) begin
        t_backlog_entry e;
        if (i_rst_n && (!job_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                job_valid <= 1'b0;
            end else if (job_backlog.size() != 0) begin
                e = job_backlog.pop_front();
                on_wire <= e.beat;
                job_valid <= 1'b1;
                gap_left = e.gap_after;
                if (e.calm) quiet_tail <= 1'b1;
            end else begin
                job_valid <= 1'b0;
            end
        end
    end

    // accepted beats go through the shadow scheduler
    always @(posedge i_clk) begin
        if (i_rst_n && job_valid && job_if.ready) begin
            in_taken <= 1'b1;
            predicted_results.push_back(schedule_job(on_wire));
            accepted_count++;
        end else begin
            in_taken <= 1'b0;
        end
    end

    // result side back-pressure
    int  rx_stall_left = 0;
    int  rx_stretch_left = 0;
    bit  rx_choppy = 1'b0;
    int  long_hold_left = 0;
    bit  long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (quiet_tail) begin
            rx_ready <= 1'b1;
        end else if (long_hold_left > 0) begin
            long_hold_left--;
            rx_ready <= 1'b0;
        end else if (!long_hold_done && result_count >= 100) begin
            // long hold-off so the output register fills and the input stalls
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD - 1;
            rx_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            rx_ready <= 1'b0;
        end else begin
            if (rx_stretch_left == 0) begin
                rx_stretch_left = $urandom_range(20, 60);
                rx_choppy = ($urandom_range(0, 2) != 0);
            end else begin
                rx_stretch_left--;
            end
            if (rx_choppy && $urandom_range(0, 3) == 0) begin
                rx_stall_left = $urandom_range(1, 9) - 1;
                rx_ready <= 1'b0;
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && res_if.valid && rx_ready) begin
            result_count++;
            got.status = t_status'(res_if.status);
            got.ran_id = res_if.ran_id;
            got.ran_level = res_if.ran_level;
            got.slice_start_pc = res_if.slice_start_pc;
            got.steps_run = res_if.steps_run;
            got.completed = res_if.completed;
            got.next_level = res_if.next_level;
            status_seen[got.status]++;
            if (got.status == STAT_DISPATCHED) begin
                if (got.completed) finished_count++;
                else demoted_count++;
            end
            if (predicted_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, status %0d", $time,
                         got.status);
                errors++;
            end else begin
                want = predicted_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("ran_id", want.ran_id, got.ran_id);
                check_field("ran_level", want.ran_level, got.ran_level);
                check_field("slice_start_pc", want.slice_start_pc, got.slice_start_pc);
                check_field("steps_run", want.steps_run, got.steps_run);
                check_field("completed", want.completed, got.completed);
                check_field("next_level", want.next_level, got.next_level);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d results seen", cycle_count,
                     result_count, pushed_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            lvl_head[i] = 0;
            lvl_fill[i] = 0;
            status_seen[i] = 0;
            slice_quantum[i] = Q_W'(1 << i);
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset quanta: empty dispatch, extremes, pc past bound, level 3 staying put
        enqueue(mk_beat(OP_DISPATCH, 0, 0, 0, 0), 0, 1'b0);
        enqueue(mk_beat(OP_ADMIT, 8'h00, 16'h0000, 16'h0000, 0), 0, 1'b0);
        enqueue(mk_beat(OP_ADMIT, 8'hFF, 16'hFFFF, 16'hFFFF, 3), 0, 1'b0);
        enqueue(mk_beat(OP_ADMIT, 8'hA5, 100, 50, 1), 0, 1'b0);
        enqueue(mk_beat(OP_ADMIT, 8'h5A, 16'h1234, 16'h1240, 2), 0, 1'b0);
        repeat (7) enqueue(mk_beat(OP_DISPATCH, 8'hC3, 16'hAAAA, 16'h5555, 2), 0, 1'b0);
        drain();

        // zero time slice, and writes to indexes that do not exist
        write_quantum(8'd0, 8'd0);
        write_quantum(8'd4, 8'h77);
        write_quantum(8'hFF, 8'h33);
        enqueue(mk_beat(OP_ADMIT, 8'h11, 10, 20, 0), 0, 1'b0);
        enqueue(mk_beat(OP_DISPATCH, 0, 0, 0, 0), 0, 1'b0);
        enqueue(mk_beat(OP_ADMIT, 8'h22, 30, 5, 0), 0, 1'b0);
        enqueue(mk_beat(OP_DISPATCH, 0, 0, 0, 0), 0, 1'b0);
        enqueue(mk_beat(OP_DISPATCH, 0, 0, 0, 0), 0, 1'b0);
        drain();

        set_quanta(255, 255, 255, 255);
        add_random_jobs(150, 85, 1'b0);
        drain();
        set_quanta(1, 1, 1, 1);
        add_random_jobs(200, 50, 1'b0);
        drain();
        set_quanta($urandom_range(1, 255), $urandom_range(1, 255),
                   $urandom_range(1, 255), $urandom_range(1, 255));
        add_random_jobs(200, 35, 1'b0);
        drain();
        set_quanta(1, 2, 4, 8);
        add_random_jobs(200, 55, 1'b0);
        drain();
        set_quanta($urandom_range(1, 255), $urandom_range(1, 255),
                   $urandom_range(1, 255), $urandom_range(1, 255));
        add_random_jobs(200, 60, 1'b0);
        drain();
        set_quanta($urandom_range(1, 255), $urandom_range(1, 255),
                   $urandom_range(1, 255), $urandom_range(1, 255));
        add_random_jobs(33, 50, 1'b0);
        // steady tail, no idling either side
        add_random_jobs(150, 50, 1'b1);
        drain();
        repeat (10) @(posedge i_clk);

        if (predicted_results.size() != 0) begin
            $display("%0d expected results never arrived", predicted_results.size());
            errors++;
        end
        $display("covered %0d jobs: %0d admitted, %0d turned away full, %0d empty dispatches",
                 result_count, status_seen[STAT_ADMITTED], status_seen[STAT_FULL],
                 status_seen[STAT_EMPTY]);
        $display("%0d slices run (%0d finished, %0d demoted), quanta 0 to 255, %0d errors",
                 status_seen[STAT_DISPATCHED], finished_count, demoted_count, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### multilevel_feedback_queue_scheduler.f
rtl/mfq_pkg.sv
rtl/mfq_if.sv
rtl/mfq_ram.sv
rtl/mfq_slice.sv
rtl/mfq_ctrl.sv
rtl/multilevel_feedback_queue_scheduler.sv
tb/sv/multilevel_feedback_queue_scheduler_test.sv
